// ===== rtl/aip_pkg.sv =====
// Shared types and constants for the ASCII integer parser.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`default_nettype none

package aip_pkg;

    // Parser sizing
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_CHARS   = 4096;
    localparam int POS_W       = $clog2(MAX_CHARS + 1);
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 6;
    localparam int PROD_W      = VALUE_WIDTH + BASE_W;
    localparam int OUT_W       = 64;
    localparam int OFFSET_W    = 13;
    localparam int CHAR_W      = 8;

    // Bases
    localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
    localparam logic [BASE_W-1:0] BASE_BAD   = BASE_W'(1);
    localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    // Digit code for a character that is no digit in any base
    localparam logic [DIGIT_W-1:0] NO_DIGIT = '1;

    // Queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_BASE = 1'b0;

    // Saturation bounds, sign-extended to the output width
    localparam logic [OUT_W-1:0] OUT_LIM = OUT_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [OUT_W-1:0] OUT_POS_MAX = OUT_LIM - OUT_W'(1);
    localparam logic [OUT_W-1:0] OUT_NEG_MIN = OUT_W'(0) - OUT_LIM;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] parsed_value;
        logic [OFFSET_W-1:0]     end_offset;
        logic                    digits_found;
        logic                    range_error;
    } t_out_item;

    // Classified character as it travels through the queue
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_space;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               last;
    } t_char_class;

endpackage

`default_nettype wire

// ===== rtl/aip_front.sv =====
// Front end: input handshake and character classification.
// Depends on aip_pkg; feeds aip_fifo.
`default_nettype none

module aip_front (
    input  wire logic              i_in_valid,
    input  aip_pkg::t_in_item      i_in_data,
    input  wire logic              i_queue_full,
    output logic                   o_in_stall,
    output logic                   o_push,
    output aip_pkg::t_char_class   o_push_data
);

    logic [aip_pkg::CHAR_W-1:0] c;
    logic [aip_pkg::CHAR_W-1:0] letter_val;

    assign c = i_in_data.text_char;

    // Hold the sender while the queue has no room
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Fold case and map letters to 10..35
    assign letter_val = (c & ~8'h20) - 8'h41 + 8'd10;

    // Classify the character
    always_comb begin
        o_push_data          = '0;
        o_push_data.last     = i_in_data.last_char;
        o_push_data.is_space = (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
        o_push_data.is_sign  = (c == 8'h2B) || (c == 8'h2D);
        o_push_data.is_minus = (c == 8'h2D);
        o_push_data.is_zero  = (c == 8'h30);
        o_push_data.is_x     = (c == 8'h78) || (c == 8'h58);
        if (c inside {[8'h30:8'h39]}) begin
            o_push_data.digit = aip_pkg::DIGIT_W'(c - 8'h30);
        end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            o_push_data.digit = letter_val[aip_pkg::DIGIT_W-1:0];
        end else begin
            o_push_data.digit = aip_pkg::NO_DIGIT;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aip_fifo.sv =====
// Short queue of classified characters between front and back.
// Depends on aip_pkg for the entry type and depth.
`default_nettype none

module aip_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  aip_pkg::t_char_class   i_push_data,
    input  wire logic              i_pop,
    output aip_pkg::t_char_class   o_pop_data,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int IDX_W = (aip_pkg::QUEUE_DEPTH > 1) ? $clog2(aip_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(aip_pkg::QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(aip_pkg::QUEUE_DEPTH - 1);

    aip_pkg::t_char_class r_mem [aip_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == CNT_W'(aip_pkg::QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + IDX_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + IDX_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aip_exec.sv =====
// Back end: parse state machine, multiply-accumulate and result register.
// Depends on aip_pkg; reads classified characters from aip_fifo.
`default_nettype none

module aip_exec (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [aip_pkg::BASE_W-1:0]  i_cfg_base,
    input  wire logic                        i_head_valid,
    input  aip_pkg::t_char_class             i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    output aip_pkg::t_out_item               o_out_data,
    input  wire logic                        i_out_stall
);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam int VW = aip_pkg::VALUE_WIDTH;
    localparam int PW = aip_pkg::PROD_W;
    localparam int BW = aip_pkg::BASE_W;
    localparam int QW = aip_pkg::POS_W;
    localparam logic [PW-1:0] LIM_P = PW'(1) << (VW - 1);
    localparam logic [QW-1:0] POS_MAX = QW'(aip_pkg::MAX_CHARS);

    // Parser state
    logic [2:0]    r_phase, n_phase;
    logic [VW-1:0] r_mag, n_mag;
    logic          r_minus, n_minus;
    logic [BW-1:0] r_base, n_base;
    logic          r_ovf, n_ovf;
    logic [QW-1:0] r_pos, n_pos;
    logic [QW-1:0] r_dend, n_dend;
    logic          r_any, n_any;

    // Result register
    logic               r_out_valid, n_out_valid;
    aip_pkg::t_out_item r_out, n_out;

    logic          out_free;
    logic          first_char;
    logic          bad_cfg;
    logic [BW-1:0] base_in;
    logic [2:0]    phase_in;
    logic [PW-1:0] prod;
    logic [PW-1:0] sum;
    logic          ovf_now;
    logic [QW-1:0] pos_next;
    logic          take;
    logic [BW-1:0] first_base;
    logic [aip_pkg::OUT_W-1:0] mag_ext;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = i_head_valid && (out_free || !i_head.last);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sample the base on the first character of a string
    assign first_char = (r_pos == '0) && (r_phase == PH_SPACE);
    assign bad_cfg    = (i_cfg_base == aip_pkg::BASE_BAD) || (i_cfg_base > aip_pkg::BASE_MAX);
    assign base_in    = first_char ? i_cfg_base : r_base;
    assign phase_in   = (first_char && bad_cfg) ? PH_DONE : r_phase;
    assign first_base = (base_in == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : base_in;

    // Multiply-accumulate; magnitude is zero whenever the base is not yet settled
    assign prod     = PW'(r_mag) * PW'(r_base);
    assign sum      = prod + PW'(i_head.digit);
    assign ovf_now  = r_ovf || (sum > LIM_P);
    assign pos_next = (r_pos >= POS_MAX) ? POS_MAX : r_pos + QW'(1);

    // Step the parser
    always_comb begin
        n_phase = phase_in;
        n_base  = base_in;
        n_minus = r_minus;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        n_dend  = r_dend;
        n_any   = r_any;
        n_pos   = r_pos;
        take    = 1'b0;
        case (phase_in)
            PH_SPACE, PH_SIGNED: begin
                if (phase_in == PH_SPACE && i_head.is_space) begin
                    n_phase = PH_SPACE;
                end else if (phase_in == PH_SPACE && i_head.is_sign) begin
                    n_minus = i_head.is_minus;
                    n_phase = PH_SIGNED;
                end else if (i_head.is_zero && (base_in == aip_pkg::BASE_AUTO ||
                                                base_in == aip_pkg::BASE_HEX)) begin
                    n_base  = (base_in == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT : base_in;
                    take    = 1'b1;
                    n_phase = PH_ZERO;
                end else begin
                    n_base = first_base;
                    if (i_head.digit >= first_base) begin
                        n_phase = PH_DONE;
                    end else begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end
                end
            end
            PH_ZERO, PH_DIGITS: begin
                if (phase_in == PH_ZERO && i_head.is_x) begin
                    n_phase = PH_PREFIX;
                end else if (i_head.digit >= base_in) begin
                    n_phase = PH_DONE;
                end else begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end
            PH_PREFIX: begin
                if (i_head.digit < aip_pkg::BASE_HEX) begin
                    n_base  = aip_pkg::BASE_HEX;
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = phase_in;
            end
        endcase
        if (take) begin
            n_ovf  = ovf_now;
            n_mag  = ovf_now ? LIM_P[VW-1:0] : sum[VW-1:0];
            n_any  = 1'b1;
            n_dend = pos_next;
        end
        n_pos = pos_next;
    end

    assign mag_ext = aip_pkg::OUT_W'(n_mag);

    // Build the result and drop the parse state on the last character
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (o_pop && i_head.last) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (n_any) begin
                n_out.digits_found = 1'b1;
                n_out.end_offset   = aip_pkg::OFFSET_W'(n_dend);
                if (n_ovf || (!n_minus && PW'(n_mag) >= LIM_P)) begin
                    n_out.range_error  = 1'b1;
                    n_out.parsed_value = n_minus ? aip_pkg::OUT_NEG_MIN
                                                 : aip_pkg::OUT_POS_MAX;
                end else begin
                    n_out.parsed_value = n_minus ? aip_pkg::OUT_W'(0) - mag_ext : mag_ext;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_mag       <= '0;
            r_minus     <= 1'b0;
            r_base      <= aip_pkg::BASE_AUTO;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_dend      <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop && i_head.last) begin
                r_phase <= PH_SPACE;
                r_mag   <= '0;
                r_minus <= 1'b0;
                r_base  <= aip_pkg::BASE_AUTO;
                r_ovf   <= 1'b0;
                r_pos   <= '0;
                r_dend  <= '0;
                r_any   <= 1'b0;
            end else if (o_pop) begin
                r_phase <= n_phase;
                r_mag   <= n_mag;
                r_minus <= n_minus;
                r_base  <= n_base;
                r_ovf   <= n_ovf;
                r_pos   <= n_pos;
                r_dend  <= n_dend;
                r_any   <= n_any;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/ascii_integer_parser_core.sv =====
// Top level of the ASCII integer parser: config register, front, queue, back.
// Depends on aip_pkg, aip_front, aip_fifo and aip_exec.
//
//   port group   direction  handshake            payload
//   in           receive    i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   out          send       o_out_valid/i_out_stall o_out_data (t_out_item)
//   config       APB slave  psel/penable/pready    paddr/pwdata/prdata
//
// One character per cycle while no stalled result holds back a last
// character; the back end's combinational 64x6 multiply-accumulate and
// overflow compare allow that rate. With the queue empty and the result
// register free, a last character taken at the input passes through the
// queue into the result register. Reset clears the queue, the parse state
// and the result valid flag, and sets number_base to 10. The input stalls
// while the two-entry queue is full; a stalled result holds, and characters
// keep flowing until the next last character reaches the back end.
`default_nettype none

module ascii_integer_parser_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  aip_pkg::t_in_item                      i_in_data,
    output logic                                   o_in_stall,
    output logic                                   o_out_valid,
    output aip_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_out_stall,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aip_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [aip_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [aip_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic [aip_pkg::BASE_W-1:0] r_number_base;
    logic                       cfg_write;
    logic                       push;
    logic                       pop;
    logic                       queue_full;
    logic                       queue_empty;
    aip_pkg::t_char_class       push_data;
    aip_pkg::t_char_class       head;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == aip_pkg::CFG_IDX_BASE);
    assign prdata    = (paddr[2] == aip_pkg::CFG_IDX_BASE)
                     ? aip_pkg::CFG_DATA_W'(r_number_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= aip_pkg::BASE_RESET;
        end else if (cfg_write) begin
            r_number_base <= pwdata[aip_pkg::BASE_W-1:0];
        end
    end

    aip_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    aip_fifo u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (head),
        .o_full      (queue_full),
        .o_empty     (queue_empty)
    );

    aip_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_base   (r_number_base),
        .i_head_valid (!queue_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/aip_checker.sv =====
// Port-level checks for the ASCII integer parser, bound to the top level.
// Depends on aip_pkg and ascii_integer_parser_core.
`default_nettype none

module aip_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  aip_pkg::t_in_item                      i_in_data,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  aip_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_out_stall
);

    // A stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("request changed while stalled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // No digits means an all-zero result
    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.digits_found |->
            o_out_data.parsed_value == '0 && o_out_data.end_offset == '0 &&
            !o_out_data.range_error)
        else $error("nonzero result without digits");

    // Saturation lands on one of the two bounds
    a_range_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |->
            o_out_data.digits_found &&
            ($unsigned(o_out_data.parsed_value) == aip_pkg::OUT_POS_MAX ||
             $unsigned(o_out_data.parsed_value) == aip_pkg::OUT_NEG_MIN))
        else $error("range error without saturated value");

    // Offset never passes the string length limit
    a_offset_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.end_offset <= aip_pkg::OFFSET_W'(aip_pkg::MAX_CHARS))
        else $error("end offset beyond limit");

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for ascii_integer_parser_core: streams characters, predicts each parse result.
// Depends on aip_pkg and the parser RTL; drives the APB port to set the number base.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    // Run sizing
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned LONG_HOLD    = 150;

    // Register map: one register, byte address 4 * index
    localparam logic [CFG_ADDR_W-1:0] ADDR_NUMBER_BASE = CFG_ADDR_W'(4 * CFG_IDX_BASE);

    // Base settings beyond those in the package
    localparam logic [BASE_W-1:0] BASE_MIN  = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_OVER = BASE_W'(37);
    localparam logic [BASE_W-1:0] BASE_TOP  = BASE_W'(63);
    localparam int unsigned       NOT_DIGIT = 99;

    // Characters
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_A_LO  = "a";
    localparam logic [7:0] CH_Z_LO  = "z";
    localparam logic [7:0] CH_A_UP  = "A";
    localparam logic [7:0] CH_Z_UP  = "Z";
    localparam logic [7:0] CH_X_LO  = "x";
    localparam logic [7:0] CH_X_UP  = "X";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TOP   = 8'hFF;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        SCAN_LEAD, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE
    } t_scan_phase;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Stimulus and scoreboard
    t_in_item    text_q[$];
    t_out_item   pending_results[$];
    int unsigned chars_made = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    logic        req_done = 1'b0;
    bit          src_quiet = 1'b0;
    bit          snk_quiet = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;

    // Parser state as predicted
    logic [BASE_W-1:0] num_base;
    t_scan_phase       sc_phase;
    logic [63:0]       sc_neg;
    bit                sc_minus;
    int unsigned       sc_radix;
    bit                sc_ovf;
    int unsigned       sc_pos;
    int unsigned       sc_end;
    bit                sc_any;

    ascii_integer_parser_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void clear_scan();
        sc_phase = SCAN_LEAD;
        sc_neg   = '0;
        sc_minus = 1'b0;
        sc_radix = 0;
        sc_ovf   = 1'b0;
        sc_pos   = 0;
        sc_end   = 0;
        sc_any   = 1'b0;
    endfunction

    function automatic int unsigned digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c) - int'(CH_0);
        if ((c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP))
            return int'(c & ~CASE_BIT) - int'(CH_A_UP) + 10;
        return NOT_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic int unsigned step_pos(input int unsigned p);
        return (p >= MAX_CHARS) ? MAX_CHARS : p + 1;
    endfunction

    // Fold one digit into the magnitude, pinning it at the limit on overflow
    function automatic void add_digit(input int unsigned d, input int unsigned p);
        logic [63:0] lim;
        logic [63:0] mag;
        lim = 64'd1 << (VALUE_WIDTH - 1);
        mag = 64'd0 - sc_neg;
        if (sc_ovf || mag > (lim - 64'(d)) / 64'(sc_radix)) begin
            sc_ovf = 1'b1;
            mag = lim;
        end else begin
            mag = mag * 64'(sc_radix) + 64'(d);
        end
        sc_neg   = 64'd0 - mag;
        sc_any   = 1'b1;
        sc_end   = step_pos(p);
        sc_phase = SCAN_DIGITS;
    endfunction

    function automatic void digit_step(input logic [7:0] c, input int unsigned p);
        int unsigned d;
        d = digit_value(c);
        if (d >= sc_radix)
            sc_phase = SCAN_DONE;
        else
            add_digit(d, p);
    endfunction

    // First character after blanks and sign: a zero may open a prefix
    function automatic void lead_digit(input logic [7:0] c, input int unsigned p);
        if (c == CH_0 && (sc_radix == BASE_AUTO || sc_radix == BASE_HEX)) begin
            if (sc_radix == BASE_AUTO)
                sc_radix = BASE_OCT;
            add_digit(0, p);
            sc_phase = SCAN_ZERO;
        end else begin
            if (sc_radix == BASE_AUTO)
                sc_radix = BASE_DEC;
            digit_step(c, p);
        end
    endfunction

    // Advance the parse by one character; return 1 with the result on a last character
    function automatic bit parse_char(input t_in_item it, output t_out_item res);
        int unsigned p;
        logic [7:0]  c;
        logic [63:0] lim;
        logic [63:0] mag;
        p = sc_pos;
        c = it.text_char;
        res = '0;
        if (p == 0 && sc_phase == SCAN_LEAD) begin
            sc_radix = num_base;
            if (sc_radix == BASE_BAD || sc_radix > BASE_MAX)
                sc_phase = SCAN_DONE;
        end
        case (sc_phase)
            SCAN_LEAD: begin
                if (!is_blank(c)) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        sc_minus = (c == CH_MINUS);
                        sc_phase = SCAN_SIGN;
                    end else begin
                        lead_digit(c, p);
                    end
                end
            end
            SCAN_SIGN: lead_digit(c, p);
            SCAN_ZERO: begin
                if (c == CH_X_LO || c == CH_X_UP)
                    sc_phase = SCAN_PREFIX;
                else
                    digit_step(c, p);
            end
            SCAN_PREFIX: begin
                if (digit_value(c) < BASE_HEX) begin
                    sc_radix = BASE_HEX;
                    add_digit(digit_value(c), p);
                end else begin
                    sc_phase = SCAN_DONE;
                end
            end
            SCAN_DIGITS: digit_step(c, p);
            default: ;
        endcase
        sc_pos = step_pos(p);
        if (!it.last_char)
            return 1'b0;

        lim = 64'd1 << (VALUE_WIDTH - 1);
        mag = 64'd0 - sc_neg;
        if (sc_any) begin
            res.digits_found = 1'b1;
            res.end_offset   = OFFSET_W'(sc_end);
            if (sc_ovf || (!sc_minus && mag >= lim)) begin
                res.range_error  = 1'b1;
                res.parsed_value = sc_minus ? 64'd0 - lim : lim - 64'd1;
            end else begin
                res.parsed_value = sc_minus ? 64'd0 - mag : mag;
            end
        end
        clear_scan();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // Extremes of the register first, then a mix weighted toward valid bases
    function automatic logic [BASE_W-1:0] sweep_base(input int unsigned k);
        case (k)
            0: return BASE_AUTO;
            1: return BASE_BAD;
            2: return BASE_MIN;
            3: return BASE_OCT;
            4: return BASE_DEC;
            5: return BASE_HEX;
            6: return BASE_MAX;
            7: return BASE_OVER;
            8: return BASE_TOP;
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return BASE_W'($urandom_range(0, 63));
                return BASE_W'($urandom_range(0, 36));
            end
        endcase
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        text_q.push_back('{text_char: c, last_char: last});
        chars_made++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    // One string: mostly blanks, sign, prefix and digits, with noise now and then
    task automatic add_random_string(input logic [BASE_W-1:0] b);
        logic [7:0]  txt[$];
        logic [7:0]  digs[$];
        logic [63:0] mag;
        int unsigned radix;
        radix = (b >= BASE_MIN && b <= BASE_MAX) ? b : BASE_DEC;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6))
                txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3))
                    txt.push_back(blank_char());
            end
            if ($urandom_range(0, 2) == 0)
                txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) == 0) begin
                txt.push_back(CH_0);
                txt.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                radix = BASE_HEX;
            end else if (b == BASE_AUTO && $urandom_range(0, 3) == 0) begin
                txt.push_back(CH_0);
                radix = BASE_OCT;
            end
            if ($urandom_range(0, 2) == 0) begin
                // render a magnitude at or near the signed limit, all ones, or random
                case ($urandom_range(0, 4))
                    0: mag = 64'h8000_0000_0000_0000;
                    1: mag = 64'h7FFF_FFFF_FFFF_FFFF;
                    2: mag = 64'h8000_0000_0000_0001;
                    3: mag = '1;
                    default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
                do begin
                    digs.push_front(digit_char(int'(mag % 64'(radix))));
                    mag = mag / 64'(radix);
                end while (mag != 0);
                foreach (digs[i])
                    txt.push_back(digs[i]);
            end else begin
                repeat ($urandom_range(1, 20))
                    txt.push_back(digit_char($urandom_range(0, radix - 1)));
            end
            repeat ($urandom_range(0, 3))
                txt.push_back(8'($urandom_range(0, 255)));
        end
        foreach (txt[i])
            push_char(txt[i], i == txt.size() - 1);
    endtask

    // Wait until every character is taken and every result is back
    task automatic drain();
        while (text_q.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUMBER_BASE;
        pwdata  <= ($urandom & ~32'h3F) | CFG_DATA_W'(b);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        num_base = b;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        err_cnt++;
        $display("cycle %0d: %s: got %0h, want %0h", cycle_cnt, what, got, want);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int unsigned phase_no;
        int unsigned start_cnt;
        logic [BASE_W-1:0] b;

        num_base = BASE_RESET;
        clear_scan();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero byte, sign, trailing junk, prefixes, invalid and widest base
        push_char(CH_NUL, 1'b1);
        push_text("\t-5");
        push_char(CH_PLUS, 1'b0);
        push_char(CH_9, 1'b0);
        push_char(CH_TOP, 1'b1);
        drain();
        write_base(BASE_AUTO);
        push_text("0xg");
        push_text("0X1f");
        push_text("017");
        drain();
        write_base(BASE_BAD);
        push_text("5");
        drain();
        write_base(BASE_MAX);
        push_text("zZ");

        // Random phases, one base each; the first one backs up the output
        phase_no  = 0;
        start_cnt = chars_made;
        while (chars_made < start_cnt + RANDOM_ITEMS) begin
            drain();
            b = sweep_base(phase_no);
            write_base(b);
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            if (phase_no == 0) begin
                src_quiet = 1'b1;
                hold_req  = 1'b1;
            end
            repeat ($urandom_range(8, 30))
                add_random_string(b);
            phase_no++;
        end

        // Decimal strings back to back at full input rate
        drain();
        write_base(BASE_DEC);
        src_quiet = 1'b1;
        snk_quiet = 1'b0;
        repeat (5) add_random_string(BASE_DEC);

        drain();
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // Offer the next request once the current one is taken; hold it while stalled
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_done) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
                in_data  <= text_q.pop_front();
                in_valid <= 1'b1;
                gap_left = src_quiet ? 0 : idle_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall results: a long hold on request, otherwise random stretches
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = snk_quiet ? 0 : idle_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin
        t_out_item res;
        t_out_item want;
        req_done <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            // predict on every accepted request
            if (in_valid && !in_stall) begin
                if (parse_char(in_data, res))
                    pending_results.push_back(res);
            end
            // compare every accepted result with the oldest prediction
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with none pending", out_data.parsed_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.parsed_value !== want.parsed_value)
                        note_mismatch("parsed_value", out_data.parsed_value,
                                      want.parsed_value);
                    if (out_data.end_offset !== want.end_offset)
                        note_mismatch("end_offset", 64'(out_data.end_offset),
                                      64'(want.end_offset));
                    if (out_data.digits_found !== want.digits_found)
                        note_mismatch("digits_found", 64'(out_data.digits_found),
                                      64'(want.digits_found));
                    if (out_data.range_error !== want.range_error)
                        note_mismatch("range_error", 64'(out_data.range_error),
                                      64'(want.range_error));
                end
            end
        end
    end

    // Give up when the run takes far longer than it should
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/aip_pkg.sv
rtl/aip_front.sv
rtl/aip_fifo.sv
rtl/aip_exec.sv
rtl/ascii_integer_parser_core.sv
rtl/aip_checker.sv
sim/testbench.sv
